// ===== rtl/fta_pkg.sv =====
// Shared types, codes and constants of the file table block allocator.
package fta_pkg;

   // Field widths fixed by the request and response formats.
   localparam int MODE_W      = 2;
   localparam int FILE_ID_W   = 16;
   localparam int STATUS_W    = 3;
   localparam int BLOCK_NUM_W = 9;
   localparam int SLOT_IDX_W  = 4;

   // Default sizes handed down from the top level.
   localparam int DEF_FILE_SLOTS  = 16;
   localparam int DEF_BLOCK_COUNT = 512;
   localparam int DEF_ID_BITS     = 16;

   // Blocks below this one are reserved from reset.
   localparam int FIRST_DATA_BLOCK = 2;

   // The used-block bitmap is kept as rows of this many bits.
   localparam int MAP_WORD_W = 32;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request mode codes; any mode with the lookup bit set is a lookup.
   localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
   localparam int MODE_LOOKUP_BIT = 1;

   typedef enum logic [1:0] {
      OP_CREATE,
      OP_DELETE,
      OP_LOOKUP
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_EXISTS    = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_NO_BLOCK  = 3'd3,
      ST_NO_SLOT   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MATCH,
      BK_EXEC,
      BK_FREE
   } back_state_type;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [FILE_ID_W-1:0] file_id;
   } req_type;

   typedef struct packed {
      logic                   ok;
      logic [STATUS_W-1:0]    status;
      logic [BLOCK_NUM_W-1:0] block_number;
      logic [SLOT_IDX_W-1:0]  slot_index;
   } rsp_type;

   // Classified request as it travels through the queue.
   typedef struct packed {
      op_type               op;
      logic [FILE_ID_W-1:0] id;
   } cmd_type;

endpackage

// ===== rtl/fta_front.sv =====
// Request front end: accept, decode the mode, mask the id, hold one command.
module fta_front #(
   parameter int ID_BITS = fta_pkg::DEF_ID_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fta_pkg::req_type req_payload,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output fta_pkg::cmd_type cmd
);
   import fta_pkg::*;

   localparam int ID_W = (ID_BITS < FILE_ID_W) ? ID_BITS : FILE_ID_W;

   logic    stg_valid_ff, stg_valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   assign req_ready = !stg_valid_ff || cmd_ready;
   assign accept    = req_valid && req_ready;
   assign cmd_valid = stg_valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      priority if (req_payload.mode == MODE_CREATE) begin
         cmd_in.op = OP_CREATE;
      end else if (req_payload.mode[MODE_LOOKUP_BIT]) begin
         cmd_in.op = OP_LOOKUP;
      end else begin
         cmd_in.op = OP_DELETE;
      end
      // drop id bits above the configured id width
      for (int k = 0; k < FILE_ID_W; k++) begin
         cmd_in.id[k] = req_payload.file_id[k] && (k < ID_W);
      end
   end

   always_comb begin
      if (accept) begin
         stg_valid_in = 1'b1;
      end else if (cmd_ready) begin
         stg_valid_in = 1'b0;
      end else begin
         stg_valid_in = stg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ===== rtl/fta_queue.sv =====
// Short command queue that decouples the front end from the back end.
module fta_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  fta_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_pop,
   output fta_pkg::cmd_type out_cmd
);
   import fta_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== rtl/fta_back.sv =====
// Back end: file table match, free block search, table and bitmap update.
module fta_back #(
   parameter int FILE_SLOTS  = fta_pkg::DEF_FILE_SLOTS,
   parameter int BLOCK_COUNT = fta_pkg::DEF_BLOCK_COUNT,
   parameter int ID_BITS     = fta_pkg::DEF_ID_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_pop,
   input  fta_pkg::cmd_type q_cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fta_pkg::rsp_type rsp_payload
);
   import fta_pkg::*;

   localparam int SLOT_W = $clog2(FILE_SLOTS);
   localparam int BLK_W  = $clog2(BLOCK_COUNT);
   localparam int ID_W   = (ID_BITS < FILE_ID_W) ? ID_BITS : FILE_ID_W;
   localparam int ROWS   = (BLOCK_COUNT + MAP_WORD_W - 1) / MAP_WORD_W;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int BIT_W  = $clog2(MAP_WORD_W);
   localparam int ADDR_W = ROW_W + BIT_W;

   // Bitmap row as it stands after reset: reserved blocks and blocks past
   // the end of the disk read as used.
   function automatic logic [MAP_WORD_W-1:0] row_init(input logic [ROW_W-1:0] row);
      logic [MAP_WORD_W-1:0] w;
      int unsigned           base;
      base = int'(row) * MAP_WORD_W;
      for (int j = 0; j < MAP_WORD_W; j++) begin
         w[j] = ((base + j) < FIRST_DATA_BLOCK) || ((base + j) >= BLOCK_COUNT);
      end
      return w;
   endfunction

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff;

   // file table
   logic [FILE_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [ID_W-1:0]       slot_id_ff [FILE_SLOTS];
   logic [BLK_W-1:0]      blk_mem [FILE_SLOTS];
   logic [BLK_W-1:0]      blk_rd_ff;
   logic [FILE_SLOTS-1:0] hit_ff, hit_in;
   logic                  found_ff, slot_free_ff, row_ok_ff;
   logic [SLOT_W-1:0]     slot_ff, hit_idx, free_idx;
   logic                  found, any_free;

   // used-block bitmap, one row per memory word
   logic [MAP_WORD_W-1:0] map_mem [ROWS];
   logic [MAP_WORD_W-1:0] map_rd_ff, map_word, map_wr_word;
   logic [ROWS-1:0]       row_valid_ff, row_full_ff;
   logic                  rd_vld_ff;
   logic [ROW_W-1:0]      rd_row_ff, srch_row, del_row, map_rd_addr;
   logic                  any_row;
   logic [BIT_W-1:0]      free_bit, del_bit;
   logic [ADDR_W-1:0]     del_addr;
   logic [BLK_W-1:0]      new_blk;

   logic                  map_rd_en, map_wr_en, slot_wr, slot_clr;
   logic                  commit, out_free, create_ok, exec_free_blk;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, res;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // match the queued id against every slot
   always_comb begin
      for (int i = 0; i < FILE_SLOTS; i++) begin
         hit_in[i] = slot_valid_ff[i] && (slot_id_ff[i] == q_cmd.id[ID_W-1:0]);
      end
   end

   // lowest matching slot, lowest empty slot, lowest row with a clear bit
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      any_free = 1'b0;
      for (int i = FILE_SLOTS - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            hit_idx = SLOT_W'(i);
         end
         if (!slot_valid_ff[i]) begin
            any_free = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
      srch_row = '0;
      any_row  = 1'b0;
      for (int r = ROWS - 1; r >= 0; r--) begin
         if (!row_full_ff[r]) begin
            any_row  = 1'b1;
            srch_row = ROW_W'(r);
         end
      end
   end

   assign found = |hit_ff;

   // bitmap row seen by the current step
   always_comb begin
      map_word = rd_vld_ff ? map_rd_ff : row_init(rd_row_ff);
      free_bit = '0;
      for (int j = MAP_WORD_W - 1; j >= 0; j--) begin
         if (!map_word[j]) begin
            free_bit = BIT_W'(j);
         end
      end
   end

   assign new_blk  = BLK_W'({rd_row_ff, free_bit});
   assign del_addr = ADDR_W'(blk_rd_ff);
   assign del_row  = del_addr[ADDR_W-1:BIT_W];
   assign del_bit  = del_addr[BIT_W-1:0];

   assign create_ok     = (cmd_ff.op == OP_CREATE) && !found_ff && row_ok_ff && slot_free_ff;
   assign exec_free_blk = (cmd_ff.op == OP_DELETE) && found_ff;

   assign map_wr_word = (state_ff == BK_FREE) ? (map_word & ~(MAP_WORD_W'(1) << del_bit))
                                              : (map_word | (MAP_WORD_W'(1) << free_bit));

   // result of the command in flight
   always_comb begin
      res.ok           = 1'b0;
      res.status       = ST_OK;
      res.block_number = '0;
      res.slot_index   = '0;
      priority if (cmd_ff.op == OP_CREATE) begin
         priority if (found_ff) begin
            res.status = ST_EXISTS;
         end else if (!row_ok_ff) begin
            res.status = ST_NO_BLOCK;
         end else if (!slot_free_ff) begin
            res.status = ST_NO_SLOT;
         end else begin
            res.ok           = 1'b1;
            res.block_number = BLOCK_NUM_W'(new_blk);
            res.slot_index   = SLOT_IDX_W'(slot_ff);
         end
      end else if (!found_ff) begin
         res.status = ST_NOT_FOUND;
      end else begin
         res.ok           = 1'b1;
         res.block_number = BLOCK_NUM_W'(blk_rd_ff);
         res.slot_index   = SLOT_IDX_W'(slot_ff);
      end
   end

   // next state
   always_comb begin
      unique case (state_ff)
         BK_IDLE:  state_in = q_valid ? BK_MATCH : BK_IDLE;
         BK_MATCH: state_in = BK_EXEC;
         BK_EXEC: begin
            priority if (exec_free_blk) begin
               state_in = BK_FREE;
            end else if (out_free) begin
               state_in = BK_IDLE;
            end else begin
               state_in = BK_EXEC;
            end
         end
         BK_FREE:  state_in = out_free ? BK_IDLE : BK_FREE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop       = 1'b0;
      map_rd_en   = 1'b0;
      map_rd_addr = srch_row;
      commit      = 1'b0;
      unique case (state_ff)
         BK_IDLE:  q_pop = q_valid;
         BK_MATCH: map_rd_en = 1'b1;
         BK_EXEC: begin
            if (exec_free_blk) begin
               map_rd_en   = 1'b1;
               map_rd_addr = del_row;
            end else begin
               commit = out_free;
            end
         end
         BK_FREE:  commit = out_free;
         default:  q_pop = 1'b0;
      endcase
   end

   assign map_wr_en = commit && ((state_ff == BK_FREE) || create_ok);
   assign slot_wr   = commit && (state_ff == BK_EXEC) && create_ok;
   assign slot_clr  = commit && (state_ff == BK_FREE);

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (slot_wr) begin
         slot_valid_in[slot_ff] = 1'b1;
      end
      if (slot_clr) begin
         slot_valid_in[slot_ff] = 1'b0;
      end
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         slot_valid_ff <= '0;
         row_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int r = 0; r < ROWS; r++) begin
            row_full_ff[r] <= &row_init(ROW_W'(r));
         end
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (map_wr_en) begin
            row_valid_ff[rd_row_ff] <= 1'b1;
            row_full_ff[rd_row_ff]  <= &map_wr_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
         hit_ff <= hit_in;
      end
      if (state_ff == BK_MATCH) begin
         found_ff     <= found;
         slot_free_ff <= any_free;
         row_ok_ff    <= any_row;
         slot_ff      <= (cmd_ff.op == OP_CREATE) ? free_idx : hit_idx;
      end
      if (map_rd_en) begin
         rd_vld_ff <= row_valid_ff[map_rd_addr];
         rd_row_ff <= map_rd_addr;
      end
      if (slot_wr) begin
         slot_id_ff[slot_ff] <= cmd_ff.id[ID_W-1:0];
      end
      if (commit) begin
         rsp_ff <= res;
      end
   end

   // block number of each slot
   always_ff @(posedge clock) begin
      if (slot_wr) begin
         blk_mem[slot_ff] <= new_blk;
      end
      if (state_ff == BK_MATCH) begin
         blk_rd_ff <= blk_mem[hit_idx];
      end
   end

   // bitmap rows
   always_ff @(posedge clock) begin
      if (map_wr_en) begin
         map_mem[rd_row_ff] <= map_wr_word;
      end
      if (map_rd_en) begin
         map_rd_ff <= map_mem[map_rd_addr];
      end
   end

   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_MATCH) |-> $onehot0(hit_ff))
      else $error("file id held in more than one slot");

   a_reserved_kept: assert property (@(posedge clock) disable iff (reset)
      (map_wr_en && (rd_row_ff == '0)) |-> (map_wr_word[FIRST_DATA_BLOCK-1:0] == '1))
      else $error("reserved block released");

   a_create_empty_slot: assert property (@(posedge clock) disable iff (reset)
      slot_wr |-> !slot_valid_ff[slot_ff])
      else $error("create overwrote a live slot");

   a_delete_used_block: assert property (@(posedge clock) disable iff (reset)
      slot_clr |-> (map_word[del_bit] && slot_valid_ff[slot_ff]))
      else $error("delete freed a block that was not in use");

endmodule

// ===== rtl/file_table_block_allocator_top.sv =====
// Top level of the file table block allocator.
//
// Requests arrive on the req_ channel (valid/ready): mode 0 creates a file,
// mode 1 deletes it, mode 2 or 3 looks it up, each by file_id. Every request
// gives exactly one transfer on the rsp_ channel with ok, status,
// block_number and slot_index, in request order.
// The back-end sequencer takes one request at a time and finishes it before
// popping the next: slot match, free search with bitmap row read, commit,
// plus a second bitmap row read to free a deleted block.
// Reset: all file slots empty, blocks 0 and 1 marked used. The bitmap rows
// carry valid bits, so there is no clearing pass and requests are taken
// as soon as reset is released.
// Stall: a response waits in the output register until taken; the back
// end holds its next commit, the two-entry command queue and the front
// stage fill, and only then does req_ready drop.
module file_table_block_allocator_top #(
   parameter int FILE_SLOTS  = fta_pkg::DEF_FILE_SLOTS,
   parameter int BLOCK_COUNT = fta_pkg::DEF_BLOCK_COUNT,
   parameter int ID_BITS     = fta_pkg::DEF_ID_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fta_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fta_pkg::rsp_type rsp_payload
);
   import fta_pkg::*;

   // front stage to queue
   logic    fr_valid, fr_ready;
   cmd_type fr_cmd;

   // queue to back end
   logic    q_valid, q_pop;
   cmd_type q_cmd;

   // decode and register the request
   fta_front #(
      .ID_BITS(ID_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .cmd_valid  (fr_valid),
      .cmd_ready  (fr_ready),
      .cmd        (fr_cmd)
   );

   // absorb commands while the back end is busy
   fta_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fr_valid),
      .in_ready (fr_ready),
      .in_cmd   (fr_cmd),
      .out_valid(q_valid),
      .out_pop  (q_pop),
      .out_cmd  (q_cmd)
   );

   // match, search, update the table and bitmap, hold the response
   fta_back #(
      .FILE_SLOTS (FILE_SLOTS),
      .BLOCK_COUNT(BLOCK_COUNT),
      .ID_BITS    (ID_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_cmd      (q_cmd),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

// ===== sim/tb_file_table_block_allocator_top.sv =====
// Self-checking testbench for the file table block allocator top level.
module tb_file_table_block_allocator_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fta_pkg::*;

   // Sizes of the instance under test.
   localparam int SLOTS  = DEF_FILE_SLOTS;
   localparam int BLOCKS = DEF_BLOCK_COUNT;

   // Mode 3 has no name of its own in the package; only the lookup bit decodes.
   localparam logic [MODE_W-1:0] MODE_LOOKUP_ALT = 2'd3;

   localparam int DIR_ROWS     = 25;
   localparam int RANDOM_ITEMS = 480;
   localparam int ID_POOL_SIZE = 24;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_LIMIT   = 2000;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_RANDOM,
      RX_SLOW
   } rx_style_type;

   // One request plus, where it can be read off at a glance, its known response.
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_item_type;

   logic    clock;
   logic    reset;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   file_table_block_allocator_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Shadow copy of the file table and the block bitmap.
   logic                   ft_valid [SLOTS];
   logic [FILE_ID_W-1:0]   ft_id    [SLOTS];
   logic [BLOCK_NUM_W-1:0] ft_block [SLOTS];
   logic                   blk_used [BLOCKS];

   stim_item_type dir_tbl [DIR_ROWS];
   stim_item_type request_q [$];
   rsp_type       pending_rsp_q [$];
   logic [FILE_ID_W-1:0] id_pool [ID_POOL_SIZE];

   int send_idx   = 0;
   int err_count  = 0;
   int burst_left = 4;
   int gap_left   = 0;
   int stat_count [8];

   stim_item_type cur_item;
   rsp_type       pred_rsp;
   rsp_type       want_rsp;
   logic          next_valid;

   rx_style_type rx_style = RX_STEADY;
   int           rx_count = 0;
   int           idle_cycles = 0;

   function automatic rsp_type mk_rsp(logic ok, status_type st, int blk, int slot);
      rsp_type r;
      r.ok           = ok;
      r.status       = st;
      r.block_number = BLOCK_NUM_W'(blk);
      r.slot_index   = SLOT_IDX_W'(slot);
      return r;
   endfunction

   function automatic stim_item_type dir_row(logic [MODE_W-1:0] mode,
                                             logic [FILE_ID_W-1:0] id,
                                             bit typed, rsp_type rsp);
      stim_item_type s;
      s.req.mode    = mode;
      s.req.file_id = id;
      s.typed       = typed;
      s.rsp         = rsp;
      return s;
   endfunction

   // Work out the response to one request and apply it to the shadow table.
   // ID_BITS equals the file_id width here, so the id is used as it comes.
   function automatic rsp_type predict_file_op(req_type r);
      rsp_type res;
      int hit;
      int blk;
      int free_slot;
      res       = '0;
      hit       = -1;
      blk       = -1;
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++)
         if (hit < 0 && ft_valid[i] && ft_id[i] == r.file_id) hit = i;
      if (r.mode == MODE_CREATE) begin
         if (hit >= 0) begin
            res = mk_rsp(1'b0, ST_EXISTS, 0, 0);
         end else begin
            for (int b = FIRST_DATA_BLOCK; b < BLOCKS; b++)
               if (blk < 0 && !blk_used[b]) blk = b;
            for (int i = 0; i < SLOTS; i++)
               if (free_slot < 0 && !ft_valid[i]) free_slot = i;
            // Block exhaustion is checked ahead of slot exhaustion.
            if (blk < 0) begin
               res = mk_rsp(1'b0, ST_NO_BLOCK, 0, 0);
            end else if (free_slot < 0) begin
               res = mk_rsp(1'b0, ST_NO_SLOT, 0, 0);
            end else begin
               ft_valid[free_slot] = 1'b1;
               ft_id[free_slot]    = r.file_id;
               ft_block[free_slot] = BLOCK_NUM_W'(blk);
               blk_used[blk]       = 1'b1;
               res = mk_rsp(1'b1, ST_OK, blk, free_slot);
            end
         end
      end else if (hit < 0) begin
         res = mk_rsp(1'b0, ST_NOT_FOUND, 0, 0);
      end else if (!r.mode[MODE_LOOKUP_BIT]) begin
         ft_valid[hit]           = 1'b0;
         blk_used[ft_block[hit]] = 1'b0;
         res = mk_rsp(1'b1, ST_OK, ft_block[hit], hit);
      end else begin
         res = mk_rsp(1'b1, ST_OK, ft_block[hit], hit);
      end
      return res;
   endfunction

   task automatic check_rsp(rsp_type want, rsp_type got);
      if (got.ok !== want.ok) begin
         $error("ok: expected %0d, got %0d", want.ok, got.ok);
         err_count++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         err_count++;
      end
      if (got.block_number !== want.block_number) begin
         $error("block_number: expected %0d, got %0d", want.block_number,
                got.block_number);
         err_count++;
      end
      if (got.slot_index !== want.slot_index) begin
         $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
         err_count++;
      end
   endtask

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Request driver and response monitor share one process so that a request
   // accepted at an edge is queued before any response at that edge is popped.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;

         // Request transfer: predict it and queue the expected response.
         if (req_valid && req_ready) begin
            cur_item = request_q[send_idx];
            send_idx++;
            pred_rsp = predict_file_op(cur_item.req);
            pending_rsp_q.push_back(cur_item.typed ? cur_item.rsp : pred_rsp);
            next_valid = 1'b0;
         end

         // Hold a waiting request; otherwise advance through the burst/gap pattern.
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (send_idx < request_q.size()) begin
               next_valid = 1'b1;
               req_payload <= request_q[send_idx].req;
               burst_left--;
               if (burst_left <= 0) begin
                  // A quarter of the bursts are long and back to back.
                  if ($urandom_range(0, 3) == 0) begin
                     burst_left = 30;
                     gap_left   = 0;
                  end else begin
                     burst_left = $urandom_range(1, 8);
                     gap_left   = $urandom_range(0, 6);
                  end
               end
            end
         end
         req_valid <= next_valid;

         // Response transfer: compare with the oldest expectation.
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp_q.size() == 0) begin
               $error("response transfer with nothing pending: status %0d block %0d",
                      rsp_payload.status, rsp_payload.block_number);
               err_count++;
            end else begin
               want_rsp = pending_rsp_q.pop_front();
               stat_count[want_rsp.status]++;
               check_rsp(want_rsp, rsp_payload);
            end
         end
      end
   end

   // Receiver back-pressure: at each reload of the style counter pick between
   // always ready, coin-flip stalls and ready only when its low two bits are set.
   always @(posedge clock) begin
      if (rx_count == 0) begin
         rx_style <= rx_style_type'($urandom_range(0, 2));
         rx_count <= 47;
      end else begin
         rx_count <= rx_count - 1;
      end
      case (rx_style)
         RX_STEADY: begin
            rsp_ready <= 1'b1;
         end
         RX_RANDOM: begin
            rsp_ready <= ($urandom_range(0, 1) == 1);
         end
         default: begin
            rsp_ready <= (rx_count[1:0] == 2'b11);
         end
      endcase
   end

   // Watchdog: drop the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer in %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int pick;
      req_type rq;

      reset = 1'b1;
      foreach (stat_count[i]) stat_count[i] = 0;
      foreach (ft_valid[i]) begin
         ft_valid[i] = 1'b0;
         ft_id[i]    = '0;
         ft_block[i] = '0;
      end
      foreach (blk_used[b]) blk_used[b] = (b < FIRST_DATA_BLOCK);

      // Directed table: empty-table misses, id extremes, duplicate create,
      // mode three as a lookup, block and slot reuse after delete, then fill
      // every slot and hit the table-full rejection.
      dir_tbl[0]  = dir_row(OP_LOOKUP, 16'h0000, 1, mk_rsp(1'b0, ST_NOT_FOUND, 0, 0));
      dir_tbl[1]  = dir_row(OP_DELETE, 16'hFFFF, 1, mk_rsp(1'b0, ST_NOT_FOUND, 0, 0));
      dir_tbl[2]  = dir_row(OP_CREATE, 16'h0000, 1, mk_rsp(1'b1, ST_OK, 2, 0));
      dir_tbl[3]  = dir_row(OP_CREATE, 16'h0000, 1, mk_rsp(1'b0, ST_EXISTS, 0, 0));
      dir_tbl[4]  = dir_row(OP_CREATE, 16'hFFFF, 1, mk_rsp(1'b1, ST_OK, 3, 1));
      dir_tbl[5]  = dir_row(MODE_LOOKUP_ALT, 16'hFFFF, 1, mk_rsp(1'b1, ST_OK, 3, 1));
      dir_tbl[6]  = dir_row(OP_DELETE, 16'h0000, 1, mk_rsp(1'b1, ST_OK, 2, 0));
      dir_tbl[7]  = dir_row(OP_CREATE, 16'hAAAA, 1, mk_rsp(1'b1, ST_OK, 2, 0));
      dir_tbl[8]  = dir_row(OP_DELETE, 16'hFFFF, 1, mk_rsp(1'b1, ST_OK, 3, 1));
      dir_tbl[9]  = dir_row(OP_CREATE, 16'h8001, 0, '0);
      dir_tbl[10] = dir_row(OP_CREATE, 16'h8002, 0, '0);
      dir_tbl[11] = dir_row(OP_CREATE, 16'h8003, 0, '0);
      dir_tbl[12] = dir_row(OP_CREATE, 16'h8004, 0, '0);
      dir_tbl[13] = dir_row(OP_CREATE, 16'h8005, 0, '0);
      dir_tbl[14] = dir_row(OP_CREATE, 16'h8006, 0, '0);
      dir_tbl[15] = dir_row(OP_CREATE, 16'h8007, 0, '0);
      dir_tbl[16] = dir_row(OP_CREATE, 16'h8008, 0, '0);
      dir_tbl[17] = dir_row(OP_CREATE, 16'h8009, 0, '0);
      dir_tbl[18] = dir_row(OP_CREATE, 16'h800A, 0, '0);
      dir_tbl[19] = dir_row(OP_CREATE, 16'h800B, 0, '0);
      dir_tbl[20] = dir_row(OP_CREATE, 16'h800C, 0, '0);
      dir_tbl[21] = dir_row(OP_CREATE, 16'h800D, 0, '0);
      dir_tbl[22] = dir_row(OP_CREATE, 16'h800E, 0, '0);
      dir_tbl[23] = dir_row(OP_CREATE, 16'h800F, 0, '0);
      dir_tbl[24] = dir_row(OP_CREATE, 16'h5A5A, 1, mk_rsp(1'b0, ST_NO_SLOT, 0, 0));
      foreach (dir_tbl[i]) request_q.push_back(dir_tbl[i]);

      // The id pool starts with the ids left in the table, so deletes and
      // lookups hit; the pool is larger than the table, so creates also
      // run into the full table.
      id_pool[0] = 16'hAAAA;
      for (int i = 1; i < SLOTS; i++) id_pool[i] = 16'h8000 | FILE_ID_W'(i);
      for (int i = SLOTS; i < ID_POOL_SIZE; i++) id_pool[i] = FILE_ID_W'($urandom);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)      rq.mode = OP_CREATE;
         else if (pick < 70) rq.mode = OP_DELETE;
         else if (pick < 95) rq.mode = OP_LOOKUP;
         else                rq.mode = MODE_LOOKUP_ALT;
         // Mostly pooled ids; the rest are unknown ids as noise.
         if ($urandom_range(0, 99) < 85)
            rq.file_id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
         else
            rq.file_id = FILE_ID_W'($urandom);
         request_q.push_back(dir_row(rq.mode, rq.file_id, 0, '0));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait until every request is sent and every response has come back,
      // then give the block time to show any stray response.
      do @(posedge clock);
      while (send_idx < request_q.size() || pending_rsp_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_rsp_q.size() != 0) begin
         $error("%0d responses never arrived", pending_rsp_q.size());
         err_count++;
      end

      $display("run: %0d requests, %0d ok, %0d duplicate creates, %0d misses",
               send_idx, stat_count[ST_OK], stat_count[ST_EXISTS],
               stat_count[ST_NOT_FOUND]);
      $display("run: %0d full-table rejections, %0d mismatches",
               stat_count[ST_NO_SLOT], err_count);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
